### rtl/assert_macros.svh
// Assertion macros for the binner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on i_clk outside reset.
`define TTB_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on i_clk outside reset.
`define TTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTB_ASSERT(lbl, ante, cons, msg)
`define TTB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/ttb_pkg.sv
// Shared constants, register codes and types of the triangle tile binner.
package ttb_pkg;

    // Grid limits (defaults of the top-level parameters)
    localparam int MAX_TILES_U_DEF = 8;
    localparam int MAX_TILES_V_DEF = 8;

    // Field widths
    localparam int TILE_W  = 6;
    localparam int TRI_W   = 16;
    localparam int CNT_W   = 16;
    localparam int PEND_W  = 17;
    localparam int VERT_W  = 16;
    localparam int COORD_W = 8;
    localparam int ENTRY_W = PEND_W + CNT_W;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (word address)
    localparam logic [1:0] REG_TILE_U = 2'd0;
    localparam logic [1:0] REG_TILE_V = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    // Register reset values
    localparam logic [3:0]       TILE_U_RST = 4'd8;
    localparam logic [3:0]       TILE_V_RST = 4'd8;
    localparam logic [CNT_W-1:0] THRESH_RST = 16'd1024;

    // Item kinds (input and result share the coding)
    localparam logic KIND_TRI = 1'b0;
    localparam logic KIND_END = 1'b1;

    // Effective configuration, counts already clamped to the grid
    typedef struct packed {
        logic [3:0]       cnt_u;
        logic [3:0]       cnt_v;
        logic [CNT_W-1:0] thresh;
    } t_cfg;

    // Clamped tile box of one triangle
    typedef struct packed {
        logic signed [COORD_W-1:0] su;
        logic signed [COORD_W-1:0] eu;
        logic signed [COORD_W-1:0] sv;
        logic signed [COORD_W-1:0] ev;
        logic                      empty;
    } t_box;

endpackage

### rtl/ttb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module ttb_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/ttb_cfg.sv
// Configuration registers behind the APB-style port, with tile count clamping.
module ttb_cfg #(
    parameter int MAX_TILES_U = ttb_pkg::MAX_TILES_U_DEF,
    parameter int MAX_TILES_V = ttb_pkg::MAX_TILES_V_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ttb_pkg::PADDR_W-1:0]  paddr,
    input  logic [ttb_pkg::PDATA_W-1:0]  pwdata,
    output logic [ttb_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output ttb_pkg::t_cfg                o_cfg
);
    import ttb_pkg::*;

    logic [3:0]       r_tile_u;
    logic [3:0]       r_tile_v;
    logic [CNT_W-1:0] r_thresh;
    logic             wr_hit;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_hit  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_u <= TILE_U_RST;
            r_tile_v <= TILE_V_RST;
            r_thresh <= THRESH_RST;
        end else if (wr_hit) begin
            case (reg_idx)
                REG_TILE_U: r_tile_u <= pwdata[3:0];
                REG_TILE_V: r_tile_v <= pwdata[3:0];
                REG_THRESH: r_thresh <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back raw register values
    always_comb begin
        case (reg_idx)
            REG_TILE_U: prdata = PDATA_W'(r_tile_u);
            REG_TILE_V: prdata = PDATA_W'(r_tile_v);
            REG_THRESH: prdata = PDATA_W'(r_thresh);
            default:    prdata = '0;
        endcase
    end

    // Zero counts act as one, oversize counts as the grid size
    always_comb begin
        if (r_tile_u == 4'd0) begin
            o_cfg.cnt_u = 4'd1;
        end else if (r_tile_u > 4'(MAX_TILES_U)) begin
            o_cfg.cnt_u = 4'(MAX_TILES_U);
        end else begin
            o_cfg.cnt_u = r_tile_u;
        end
        if (r_tile_v == 4'd0) begin
            o_cfg.cnt_v = 4'd1;
        end else if (r_tile_v > 4'(MAX_TILES_V)) begin
            o_cfg.cnt_v = 4'(MAX_TILES_V);
        end else begin
            o_cfg.cnt_v = r_tile_v;
        end
        o_cfg.thresh = r_thresh;
    end

endmodule

### rtl/ttb_box.sv
// Bounding box setup: vertex min/max, scaling to tile units and clamping.
module ttb_box (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert0_x,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert0_y,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert1_x,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert1_y,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert2_x,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert2_y,
    input  ttb_pkg::t_cfg                      i_cfg,
    output ttb_pkg::t_box                      o_box
);
    import ttb_pkg::*;

    function automatic logic signed [VERT_W-1:0] min3(
        input logic signed [VERT_W-1:0] a,
        input logic signed [VERT_W-1:0] b,
        input logic signed [VERT_W-1:0] c
    );
        logic signed [VERT_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [VERT_W-1:0] max3(
        input logic signed [VERT_W-1:0] a,
        input logic signed [VERT_W-1:0] b,
        input logic signed [VERT_W-1:0] c
    );
        logic signed [VERT_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Coordinate times tile count, divided by 4096 toward zero
    function automatic logic signed [COORD_W-1:0] scale(
        input logic signed [VERT_W-1:0] x,
        input logic [3:0]               cnt
    );
        logic signed [VERT_W+4:0] prod;
        logic signed [VERT_W+4:0] adj;
        prod = x * $signed({1'b0, cnt});
        adj  = prod[VERT_W+4] ? (prod + (VERT_W+5)'(4095)) : prod;
        return $signed(adj[19:12]);
    endfunction

    logic signed [VERT_W-1:0]  r_min_x, r_max_x, r_min_y, r_max_y;
    logic signed [COORD_W-1:0] qsu, qeu, qsv, qev;
    logic signed [COORD_W-1:0] lim_u, lim_v;
    t_box                      n_box;
    t_box                      r_box;

    // Stage 1: extents of the triangle
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_min_x <= min3(i_vert0_x, i_vert1_x, i_vert2_x);
            r_max_x <= max3(i_vert0_x, i_vert1_x, i_vert2_x);
            r_min_y <= min3(i_vert0_y, i_vert1_y, i_vert2_y);
            r_max_y <= max3(i_vert0_y, i_vert1_y, i_vert2_y);
        end
    end

    // Stage 2: tile coordinates, clamped to the grid
    always_comb begin
        qsu   = scale(r_min_x, i_cfg.cnt_u);
        qeu   = scale(r_max_x, i_cfg.cnt_u);
        qsv   = scale(r_min_y, i_cfg.cnt_v);
        qev   = scale(r_max_y, i_cfg.cnt_v);
        lim_u = $signed({4'd0, i_cfg.cnt_u}) - 8'sd1;
        lim_v = $signed({4'd0, i_cfg.cnt_v}) - 8'sd1;
        n_box.su    = (qsu < 8'sd0) ? 8'sd0 : qsu;
        n_box.sv    = (qsv < 8'sd0) ? 8'sd0 : qsv;
        n_box.eu    = (qeu > lim_u) ? lim_u : qeu;
        n_box.ev    = (qev > lim_v) ? lim_v : qev;
        n_box.empty = (n_box.su > n_box.eu) || (n_box.sv > n_box.ev);
    end

    always_ff @(posedge i_clk) begin
        r_box <= n_box;
    end

    assign o_box = r_box;

endmodule

### rtl/triangle_tile_binner.sv
// Triangle tile binner top level: sequencer around the per-tile count memory.
//
// Input channel (i_valid / o_stall): one request is either a triangle
// (i_kind 0, three Q4.12 vertices) or an end of batch (i_kind 1). A request
// is taken only when the block is idle; o_stall stays high while one is at work.
// Output channel (o_valid / i_stall): one result per covered tile for a
// triangle, one per touched tile at end of batch; o_last marks the final one.
// Sequence: a triangle passes box setup (S_BOX1, S_BOX2), then for each covered
// tile a memory read (S_TRD) and a read-modify-write (S_TWR) that emits its bin
// entry; a box off the grid returns to idle from S_BOX2. An end of batch walks
// every tile number in S_WALK, skipping untouched tiles and reading touched ones,
// writes each touched tile back in S_EWR and closes the batch in S_EFIN. Each
// write-back uses the memory read ahead of it.
// Reset: configuration returns to 8x8 tiles and threshold 1024, the per-tile
// valid bits clear at once so all counts read as zero; no clearing pass.
// A stalled receiver holds the output register; the block then waits before
// writing the next tile, so no result is lost or reordered.
// Configuration must be written by the user over the APB-style port only while
// idle; the block itself does not enforce it.
`include "assert_macros.svh"

module triangle_tile_binner #(
    parameter int MAX_TILES_U = ttb_pkg::MAX_TILES_U_DEF,
    parameter int MAX_TILES_V = ttb_pkg::MAX_TILES_V_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_kind,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert0_x,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert0_y,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert1_x,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert1_y,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert2_x,
    input  logic signed [ttb_pkg::VERT_W-1:0]  i_vert2_y,
    // result channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_result_kind,
    output logic [ttb_pkg::TILE_W-1:0]         o_tile_index,
    output logic [ttb_pkg::TRI_W-1:0]          o_triangle_number,
    output logic [ttb_pkg::CNT_W-1:0]          o_tile_batch_count,
    output logic                               o_flush,
    output logic                               o_last,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ttb_pkg::PADDR_W-1:0]        paddr,
    input  logic [ttb_pkg::PDATA_W-1:0]        pwdata,
    output logic [ttb_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import ttb_pkg::*;

    localparam int SLOTS = MAX_TILES_U * MAX_TILES_V;
    localparam int TW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UW    = (MAX_TILES_U > 1) ? $clog2(MAX_TILES_U) : 1;
    localparam int VW    = (MAX_TILES_V > 1) ? $clog2(MAX_TILES_V) : 1;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BOX1 = 4'd1;
    localparam logic [3:0] S_BOX2 = 4'd2;
    localparam logic [3:0] S_TRD  = 4'd3;
    localparam logic [3:0] S_TWR  = 4'd4;
    localparam logic [3:0] S_WALK = 4'd5;
    localparam logic [3:0] S_EWR  = 4'd6;
    localparam logic [3:0] S_EFIN = 4'd7;

    t_cfg cfg;
    t_box box;

    // control state
    logic [3:0]       r_state, n_state;
    logic [TRI_W-1:0] r_tri_cnt, n_tri_cnt;
    logic [SLOTS-1:0] r_bat_vld, n_bat_vld;
    logic [SLOTS-1:0] r_pend_vld, n_pend_vld;
    logic             r_o_valid, n_o_valid;
    logic             r_hold_vld, n_hold_vld;

    // payload
    logic [TW-1:0]    r_addr, n_addr;
    logic [UW-1:0]    r_u, n_u, r_su, n_su, r_eu, n_eu;
    logic [VW-1:0]    r_v, n_v, r_ev, n_ev;
    logic             r_o_kind, n_o_kind;
    logic [TW-1:0]    r_o_tile, n_o_tile;
    logic [TRI_W-1:0] r_o_tri, n_o_tri;
    logic [CNT_W-1:0] r_o_cnt, n_o_cnt;
    logic             r_o_flush, n_o_flush;
    logic             r_o_last, n_o_last;
    logic [TW-1:0]    r_hold_tile, n_hold_tile;
    logic [CNT_W-1:0] r_hold_cnt, n_hold_cnt;
    logic             r_hold_flush, n_hold_flush;

    // memory port
    logic               ram_we, ram_re;
    logic [TW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_q;

    logic               in_accept;
    logic               out_free;
    logic [7:0]         tile_sum;
    logic [PEND_W-1:0]  pend_eff, pend_new;
    logic [PEND_W-1:0]  pend_sum;
    logic [CNT_W-1:0]   bat_eff, bat_inc;
    logic               over;
    logic               tri_last;
    logic               walk_end;

    ttb_cfg #(
        .MAX_TILES_U (MAX_TILES_U),
        .MAX_TILES_V (MAX_TILES_V)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ttb_box u_box (
        .i_clk     (i_clk),
        .i_load    (in_accept && (i_kind == KIND_TRI)),
        .i_vert0_x (i_vert0_x),
        .i_vert0_y (i_vert0_y),
        .i_vert1_x (i_vert1_x),
        .i_vert1_y (i_vert1_y),
        .i_vert2_x (i_vert2_x),
        .i_vert2_y (i_vert2_y),
        .i_cfg     (cfg),
        .o_box     (box)
    );

    // {pending count, batch count} per tile
    ttb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_addr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_q)
    );

    assign o_stall   = (r_state != S_IDLE);
    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_o_valid || !i_stall;

    // Read data of the current tile; an entry never written reads as zero
    always_comb begin
        pend_eff = r_pend_vld[r_addr] ? ram_q[ENTRY_W-1:CNT_W] : '0;
        bat_eff  = r_bat_vld[r_addr] ? ram_q[CNT_W-1:0] : '0;
        bat_inc  = (bat_eff == {CNT_W{1'b1}}) ? bat_eff : bat_eff + CNT_W'(1);
        pend_sum = pend_eff + PEND_W'(bat_eff);
        over     = pend_sum > PEND_W'(cfg.thresh);
        pend_new = over ? '0 : pend_sum;
    end

    assign tile_sum = 8'(r_u) + 8'(r_v) * 8'(cfg.cnt_u);
    assign tri_last = (r_u == r_eu) && (r_v == r_ev);
    assign walk_end = (r_addr == TW'(SLOTS - 1));

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_tri_cnt    = r_tri_cnt;
        n_bat_vld    = r_bat_vld;
        n_pend_vld   = r_pend_vld;
        n_o_valid    = r_o_valid && i_stall;
        n_hold_vld   = r_hold_vld;
        n_addr       = r_addr;
        n_u          = r_u;
        n_v          = r_v;
        n_su         = r_su;
        n_eu         = r_eu;
        n_ev         = r_ev;
        n_o_kind     = r_o_kind;
        n_o_tile     = r_o_tile;
        n_o_tri      = r_o_tri;
        n_o_cnt      = r_o_cnt;
        n_o_flush    = r_o_flush;
        n_o_last     = r_o_last;
        n_hold_tile  = r_hold_tile;
        n_hold_cnt   = r_hold_cnt;
        n_hold_flush = r_hold_flush;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = r_addr;
        ram_wdata    = '0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_kind == KIND_END) begin
                        n_addr  = '0;
                        n_state = S_WALK;
                    end else begin
                        n_state = S_BOX1;
                    end
                end
            end
            S_BOX1: begin
                n_state = S_BOX2;
            end
            S_BOX2: begin
                if (box.empty) begin
                    n_tri_cnt = r_tri_cnt + TRI_W'(1);
                    n_state   = S_IDLE;
                end else begin
                    n_u     = box.su[UW-1:0];
                    n_su    = box.su[UW-1:0];
                    n_eu    = box.eu[UW-1:0];
                    n_v     = box.sv[VW-1:0];
                    n_ev    = box.ev[VW-1:0];
                    n_state = S_TRD;
                end
            end
            // read the tile's counts
            S_TRD: begin
                ram_re    = 1'b1;
                ram_raddr = tile_sum[TW-1:0];
                n_addr    = tile_sum[TW-1:0];
                n_state   = S_TWR;
            end
            // bump the batch count and emit a bin entry
            S_TWR: begin
                if (out_free) begin
                    ram_we             = 1'b1;
                    ram_wdata          = {pend_eff, bat_inc};
                    n_bat_vld[r_addr]  = 1'b1;
                    n_pend_vld[r_addr] = 1'b1;
                    n_o_valid          = 1'b1;
                    n_o_kind           = KIND_TRI;
                    n_o_tile           = r_addr;
                    n_o_tri            = r_tri_cnt;
                    n_o_cnt            = '0;
                    n_o_flush          = 1'b0;
                    n_o_last           = tri_last;
                    if (tri_last) begin
                        n_tri_cnt = r_tri_cnt + TRI_W'(1);
                        n_state   = S_IDLE;
                    end else begin
                        if (r_u == r_eu) begin
                            n_u = r_su;
                            n_v = r_v + VW'(1);
                        end else begin
                            n_u = r_u + UW'(1);
                        end
                        n_state = S_TRD;
                    end
                end
            end
            // batch end: skip untouched tiles, read touched ones
            S_WALK: begin
                if (r_bat_vld[r_addr]) begin
                    ram_re  = 1'b1;
                    n_state = S_EWR;
                end else if (walk_end) begin
                    n_state = S_EFIN;
                end else begin
                    n_addr = r_addr + TW'(1);
                end
            end
            // fold batch count into pending; previous append leaves the hold stage
            S_EWR: begin
                if (!r_hold_vld || out_free) begin
                    ram_we             = 1'b1;
                    ram_wdata          = {pend_new, bat_eff};
                    n_pend_vld[r_addr] = 1'b1;
                    if (r_hold_vld) begin
                        n_o_valid = 1'b1;
                        n_o_kind  = KIND_END;
                        n_o_tile  = r_hold_tile;
                        n_o_tri   = '0;
                        n_o_cnt   = r_hold_cnt;
                        n_o_flush = r_hold_flush;
                        n_o_last  = 1'b0;
                    end
                    n_hold_vld   = 1'b1;
                    n_hold_tile  = r_addr;
                    n_hold_cnt   = bat_eff;
                    n_hold_flush = over;
                    if (walk_end) begin
                        n_state = S_EFIN;
                    end else begin
                        n_addr  = r_addr + TW'(1);
                        n_state = S_WALK;
                    end
                end
            end
            // last append goes out marked final; batch restarts
            S_EFIN: begin
                if (!r_hold_vld || out_free) begin
                    if (r_hold_vld) begin
                        n_o_valid = 1'b1;
                        n_o_kind  = KIND_END;
                        n_o_tile  = r_hold_tile;
                        n_o_tri   = '0;
                        n_o_cnt   = r_hold_cnt;
                        n_o_flush = r_hold_flush;
                        n_o_last  = 1'b1;
                    end
                    n_hold_vld = 1'b0;
                    n_bat_vld  = '0;
                    n_tri_cnt  = '0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tri_cnt  <= '0;
            r_bat_vld  <= '0;
            r_pend_vld <= '0;
            r_o_valid  <= 1'b0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_tri_cnt  <= n_tri_cnt;
            r_bat_vld  <= n_bat_vld;
            r_pend_vld <= n_pend_vld;
            r_o_valid  <= n_o_valid;
            r_hold_vld <= n_hold_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_u          <= n_u;
        r_v          <= n_v;
        r_su         <= n_su;
        r_eu         <= n_eu;
        r_ev         <= n_ev;
        r_o_kind     <= n_o_kind;
        r_o_tile     <= n_o_tile;
        r_o_tri      <= n_o_tri;
        r_o_cnt      <= n_o_cnt;
        r_o_flush    <= n_o_flush;
        r_o_last     <= n_o_last;
        r_hold_tile  <= n_hold_tile;
        r_hold_cnt   <= n_hold_cnt;
        r_hold_flush <= n_hold_flush;
    end

    assign o_valid            = r_o_valid;
    assign o_result_kind      = r_o_kind;
    assign o_tile_index       = TILE_W'(r_o_tile);
    assign o_triangle_number  = r_o_tri;
    assign o_tile_batch_count = r_o_cnt;
    assign o_flush            = r_o_flush;
    assign o_last             = r_o_last;

    // Checks
    `TTB_ASSERT(a_hold_in_walk, r_hold_vld, r_state >= S_WALK, "hold valid outside batch end")
    `TTB_ASSERT(a_ram_single_access, ram_we, !ram_re, "tile memory read and write together")
    `TTB_ASSERT_NEXT(a_tile_marked, ram_we, r_bat_vld[$past(r_addr)], "tile not marked")
    `TTB_ASSERT_NEXT(a_batch_cleared, r_state == S_EFIN && !n_hold_vld, ~|r_bat_vld, "batch kept")
    `TTB_ASSERT(a_bin_fields, r_o_valid && r_o_kind == KIND_TRI, ~|r_o_cnt && !r_o_flush, "bad bin")

endmodule

### tb/tb_triangle_tile_binner.sv
`timescale 1ns / 1ps
// Self-checking testbench for the triangle tile binner: queued requests, bin predictor, scoreboard.
module tb_triangle_tile_binner;
    import ttb_pkg::*;

    localparam int MAX_U          = MAX_TILES_U_DEF;
    localparam int MAX_V          = MAX_TILES_V_DEF;
    localparam int N_TILES        = MAX_U * MAX_V;
    localparam int RAND_PHASES    = 6;
    localparam int RAND_PER_PHASE = 50;
    localparam int SETTLE_CYCLES  = 200;
    localparam int LIMIT          = 4000000;

    // One request on the input channel
    typedef struct packed {
        logic                     kind;
        logic signed [VERT_W-1:0] x0;
        logic signed [VERT_W-1:0] y0;
        logic signed [VERT_W-1:0] x1;
        logic signed [VERT_W-1:0] y1;
        logic signed [VERT_W-1:0] x2;
        logic signed [VERT_W-1:0] y2;
    } t_tri_req;

    // One bin entry or queue append
    typedef struct packed {
        logic              kind;
        logic [TILE_W-1:0] tile;
        logic [TRI_W-1:0]  tri_num;
        logic [CNT_W-1:0]  cnt;
        logic              flush;
        logic              last;
    } t_bin_res;

    // Clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // DUT inputs, known from time zero
    logic                     i_valid   = 1'b0;
    logic                     i_kind    = 1'b0;
    logic signed [VERT_W-1:0] i_vert0_x = '0;
    logic signed [VERT_W-1:0] i_vert0_y = '0;
    logic signed [VERT_W-1:0] i_vert1_x = '0;
    logic signed [VERT_W-1:0] i_vert1_y = '0;
    logic signed [VERT_W-1:0] i_vert2_x = '0;
    logic signed [VERT_W-1:0] i_vert2_y = '0;
    logic                     i_stall   = 1'b0;
    logic                     psel      = 1'b0;
    logic                     penable   = 1'b0;
    logic                     pwrite    = 1'b0;
    logic [PADDR_W-1:0]       paddr     = '0;
    logic [PDATA_W-1:0]       pwdata    = '0;

    // DUT outputs
    logic               o_stall;
    logic               o_valid;
    logic               o_result_kind;
    logic [TILE_W-1:0]  o_tile_index;
    logic [TRI_W-1:0]   o_triangle_number;
    logic [CNT_W-1:0]   o_tile_batch_count;
    logic               o_flush;
    logic               o_last;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    triangle_tile_binner dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_kind             (i_kind),
        .i_vert0_x          (i_vert0_x),
        .i_vert0_y          (i_vert0_y),
        .i_vert1_x          (i_vert1_x),
        .i_vert1_y          (i_vert1_y),
        .i_vert2_x          (i_vert2_x),
        .i_vert2_y          (i_vert2_y),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_result_kind      (o_result_kind),
        .o_tile_index       (o_tile_index),
        .o_triangle_number  (o_triangle_number),
        .o_tile_batch_count (o_tile_batch_count),
        .o_flush            (o_flush),
        .o_last             (o_last),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    // Shadow configuration and per-tile state
    logic [3:0]        cfg_tiles_u = TILE_U_RST;
    logic [3:0]        cfg_tiles_v = TILE_V_RST;
    logic [CNT_W-1:0]  cfg_thresh  = THRESH_RST;
    logic [PEND_W-1:0] pend_cnt  [N_TILES];
    logic [CNT_W-1:0]  batch_cnt [N_TILES];
    logic [TRI_W-1:0]  tri_ctr = '0;

    t_tri_req req_q[$];
    t_bin_res tile_result_q[$];
    t_tri_req cur_req;
    int       fail_cnt   = 0;
    int       cycle_cnt  = 0;
    int       gap_left   = 0;
    int       stall_left = 0;
    bit       quiet      = 1'b0;

    initial begin
        for (int t = 0; t < N_TILES; t++) begin
            pend_cnt[t]  = '0;
            batch_cnt[t] = '0;
        end
    end

    // Append to the request and expected-result queues
    function automatic void add_req(t_tri_req r);
        req_q = {req_q, r};
    endfunction

    function automatic void add_res(t_bin_res r);
        tile_result_q = {tile_result_q, r};
    endfunction

    // Count 0 acts as 1, counts above the grid act as the grid size
    function automatic int eff_count(logic [3:0] c, int maxc);
        if (c == 4'd0) return 1;
        if (int'(c) > maxc) return maxc;
        return int'(c);
    endfunction

    function automatic int min3(int a, int b, int c);
        int m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic int max3(int a, int b, int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Bounding box binning: one bin entry per covered tile, v outer, u inner
    function automatic void bin_triangle(t_tri_req r);
        int cu, cv, su, eu, sv, ev;
        int ax, ay, bx, by, qx, qy;
        logic [TILE_W-1:0] t;
        t_bin_res res;
        cu = eff_count(cfg_tiles_u, MAX_U);
        cv = eff_count(cfg_tiles_v, MAX_V);
        ax = int'(r.x0);
        ay = int'(r.y0);
        bx = int'(r.x1);
        by = int'(r.y1);
        qx = int'(r.x2);
        qy = int'(r.y2);
        // int division truncates toward zero
        su = (min3(ax, bx, qx) * cu) / 4096;
        eu = (max3(ax, bx, qx) * cu) / 4096;
        sv = (min3(ay, by, qy) * cv) / 4096;
        ev = (max3(ay, by, qy) * cv) / 4096;
        if (su < 0) su = 0;
        if (sv < 0) sv = 0;
        if (eu > cu - 1) eu = cu - 1;
        if (ev > cv - 1) ev = cv - 1;
        for (int v = sv; v <= ev; v++) begin
            for (int u = su; u <= eu; u++) begin
                t = TILE_W'((u + v * cu) & (N_TILES - 1));
                if (batch_cnt[t] != '1) batch_cnt[t] = batch_cnt[t] + 1'b1;
                res.kind    = KIND_TRI;
                res.tile    = t;
                res.tri_num = tri_ctr;
                res.cnt     = '0;
                res.flush   = 1'b0;
                res.last    = (u == eu) && (v == ev);
                add_res(res);
            end
        end
        // off-grid boxes still use up a triangle number
        tri_ctr = tri_ctr + 1'b1;
    endfunction

    // Batch close: append every touched tile, flush when pending passes threshold
    function automatic void close_batch();
        int final_t;
        logic [PEND_W-1:0] sum;
        t_bin_res res;
        final_t = -1;
        for (int t = 0; t < N_TILES; t++)
            if (batch_cnt[t] != '0) final_t = t;
        for (int t = 0; t < N_TILES; t++) begin
            if (batch_cnt[t] == '0) continue;
            sum = pend_cnt[t] + {1'b0, batch_cnt[t]};
            res.kind    = KIND_END;
            res.tile    = TILE_W'(t);
            res.tri_num = '0;
            res.cnt     = batch_cnt[t];
            res.flush   = (sum > {1'b0, cfg_thresh});
            res.last    = (t == final_t);
            pend_cnt[t] = res.flush ? '0 : sum;
            add_res(res);
        end
        for (int t = 0; t < N_TILES; t++) batch_cnt[t] = '0;
        tri_ctr = '0;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_tri_req mk_tri(int ax, int ay, int bx, int by, int qx, int qy);
        t_tri_req r;
        r.kind = KIND_TRI;
        r.x0   = VERT_W'(ax);
        r.y0   = VERT_W'(ay);
        r.x1   = VERT_W'(bx);
        r.y1   = VERT_W'(by);
        r.x2   = VERT_W'(qx);
        r.y2   = VERT_W'(qy);
        return r;
    endfunction

    function automatic t_tri_req mk_end();
        t_tri_req r;
        r      = mk_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        r.kind = KIND_END;
        return r;
    endfunction

    function automatic int jitter(int c, int s);
        return c + int'($urandom_range(0, 2 * s)) - s;
    endfunction

    // Random request: mostly small on-screen triangles, some wild ones, a few batch ends
    function automatic t_tri_req rand_req();
        int pick, cx, cy, s;
        pick = $urandom_range(0, 99);
        if (pick < 8) return mk_end();
        if (pick < 23) return mk_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        cx = int'($urandom_range(0, 6143)) - 1024;
        cy = int'($urandom_range(0, 6143)) - 1024;
        s  = (pick < 90) ? $urandom_range(0, 600) : $urandom_range(600, 3000);
        return mk_tri(jitter(cx, s), jitter(cy, s), jitter(cx, s),
                      jitter(cy, s), jitter(cx, s), jitter(cy, s));
    endfunction

    // Request driver; predicts results at the accepting edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            if (i_valid && !o_stall) begin
                if (cur_req.kind == KIND_TRI) bin_triangle(cur_req);
                else close_batch();
            end
            if (!i_valid || !o_stall) begin
                if (gap_left == 0 && req_q.size() != 0) begin
                    cur_req = req_q.pop_front();
                    i_kind    <= cur_req.kind;
                    i_vert0_x <= cur_req.x0;
                    i_vert0_y <= cur_req.y0;
                    i_vert1_x <= cur_req.x1;
                    i_vert1_y <= cur_req.y1;
                    i_vert2_x <= cur_req.x2;
                    i_vert2_y <= cur_req.y2;
                    i_valid   <= 1'b1;
                    gap_left  = pick_idle();
                end else begin
                    if (gap_left > 0) gap_left--;
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and scoreboard, random receiver stalls
    always @(posedge i_clk) begin
        t_bin_res want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (tile_result_q.size() == 0) begin
                    $error("result with nothing pending: kind %0d tile %0d",
                           o_result_kind, o_tile_index);
                    fail_cnt++;
                end else begin
                    want = tile_result_q.pop_front();
                    if (o_result_kind !== want.kind) begin
                        $error("result_kind: expected %0d, got %0d", want.kind, o_result_kind);
                        fail_cnt++;
                    end
                    if (o_tile_index !== want.tile) begin
                        $error("tile_index: expected %0d, got %0d", want.tile, o_tile_index);
                        fail_cnt++;
                    end
                    if (o_triangle_number !== want.tri_num) begin
                        $error("triangle_number: expected %0d, got %0d",
                               want.tri_num, o_triangle_number);
                        fail_cnt++;
                    end
                    if (o_tile_batch_count !== want.cnt) begin
                        $error("tile_batch_count: expected %0d, got %0d",
                               want.cnt, o_tile_batch_count);
                        fail_cnt++;
                    end
                    if (o_flush !== want.flush) begin
                        $error("flush: expected %0d, got %0d", want.flush, o_flush);
                        fail_cnt++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, o_last);
                        fail_cnt++;
                    end
                end
            end
            if (stall_left == 0) stall_left = pick_idle();
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < LIMIT) @(posedge i_clk) cycle_cnt++;
        $display("FAILURE");
        $finish;
    end

    // APB write: setup, then access until pready
    task automatic apb_write(logic [1:0] idx, logic [PDATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TILE_U: cfg_tiles_u = val[3:0];
            REG_TILE_V: cfg_tiles_v = val[3:0];
            REG_THRESH: cfg_thresh  = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [3:0] cu, logic [3:0] cv, logic [CNT_W-1:0] thr);
        apb_write(REG_TILE_U, ($urandom & 32'hFFFF_FFF0) | PDATA_W'(cu));
        apb_write(REG_TILE_V, ($urandom & 32'hFFFF_FFF0) | PDATA_W'(cv));
        apb_write(REG_THRESH, ($urandom & 32'hFFFF_0000) | PDATA_W'(thr));
    endtask

    // Wait until every request is taken and every result seen, then let the walk finish
    task automatic wait_idle();
        do @(negedge i_clk);
        while (req_q.size() != 0 || i_valid || tile_result_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        logic [3:0]       set_u, set_v;
        logic [CNT_W-1:0] set_thr;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset grid (8x8, threshold 1024)
        add_req(mk_tri(0, 0, 4095, 0, 0, 4095));                    // whole grid
        add_req(mk_tri(-32768, -32768, -32768, -32768, -32768, -32768));
        add_req(mk_tri(32767, 32767, 32767, 32767, 32767, 32767));
        add_req(mk_tri(-32768, -32768, 32767, 32767, 0, 0));        // clamped both ways
        add_req(mk_tri(100, 100, 200, 100, 100, 200));
        add_req(mk_tri(-500, -500, -1, -1, -300, -20));             // truncates to zero
        add_req(mk_tri(511, 512, 512, 1023, 1024, 600));            // tile edges
        add_req(mk_tri(2048, 2048, 2048, 2048, 2048, 2048));        // degenerate point
        add_req(mk_tri(4096, 0, 5000, 100, 4500, 50));              // right of grid
        add_req(mk_tri(-4096, 3000, -5000, 3500, -4097, 3900));     // left of grid
        add_req(mk_end());
        add_req(mk_end());                                          // empty batch
        add_req(mk_tri(0, -8192, 4095, -4096, 1000, -5000));        // above grid
        add_req(mk_end());                                          // still empty
        add_req(mk_tri(3584, 3584, 4095, 4095, 3600, 4000));        // last tile
        add_req(mk_tri(0, 0, 511, 0, 0, 511));                      // batch left open
        wait_idle();

        // Random phases, grid and threshold changed between them (batch may stay open)
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin set_u = 4'd3;  set_v = 4'd5;  set_thr = 16'd2;     end
                1: begin set_u = 4'd0;  set_v = 4'd15; set_thr = 16'd0;     end
                2: begin set_u = 4'd15; set_v = 4'd0;  set_thr = 16'hFFFF;  end
                3: begin set_u = 4'd1;  set_v = 4'd1;  set_thr = 16'd1;     end
                4: begin set_u = 4'd8;  set_v = 4'd8;  set_thr = CNT_W'($urandom); end
                default: begin
                    set_u   = 4'($urandom_range(0, 15));
                    set_v   = 4'($urandom_range(0, 15));
                    set_thr = CNT_W'($urandom_range(0, 40));
                end
            endcase
            set_grid(set_u, set_v, set_thr);
            @(negedge i_clk);
            quiet = (p == 2);
            for (int k = 0; k < RAND_PER_PHASE; k++) add_req(rand_req());
            wait_idle();
        end

        if (fail_cnt == 0 && tile_result_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ttb_pkg.sv
rtl/ttb_ram.sv
rtl/ttb_cfg.sv
rtl/ttb_box.sv
rtl/triangle_tile_binner.sv
tb/tb_triangle_tile_binner.sv
